/* rtl/lps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load profile statistics package
// Shared widths, item types and a helper function for the load profile block.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int HOUR_W        = 5;
    localparam int MINUTE_W      = 6;
    localparam int TIME_W        = 7;
    localparam int DAY_SUM_W     = 23;
    localparam int HOURS_PER_DAY = 24;
    localparam int QUEUE_DEPTH   = 4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] power_sample;
    } sample_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour_index;
        logic [SAMPLE_W-1:0] hour_average;
        logic                day_done;
        logic [SAMPLE_W-1:0] peak_value;
        logic [HOUR_W-1:0]   peak_hour;
        logic [MINUTE_W-1:0] peak_minute;
        logic [SAMPLE_W-1:0] base_value;
        logic [HOUR_W-1:0]   base_hour;
        logic [MINUTE_W-1:0] base_minute;
        logic [SAMPLE_W-1:0] day_mean;
    } result_t;

    // Work handed from the front to the back; day_mean is filled in by the back.
    typedef struct packed {
        result_t              res;
        logic [DAY_SUM_W-1:0] day_sum;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [MINUTE_W-1:0] minute_of(input logic [1:0] quarter);
        logic [MINUTE_W-1:0] minute;
        case (quarter)
            2'd0:    minute = 6'd0;
            2'd1:    minute = 6'd15;
            2'd2:    minute = 6'd30;
            default: minute = 6'd45;
        endcase
        return minute;
    endfunction

endpackage

/* rtl/lps_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load profile stream interface
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface lps_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/lps_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load profile front end
// Accepts samples, keeps time of day, sums and extremes, and queues results.
// ----------------------------------------------------------------------------
module lps_front
    import lps_pkg::*;
#(
    parameter int SAMPLES_PER_DAY = 96,
    parameter int SAMPLE_WIDTH    = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    lps_stream_if.sink    samples,
    input  queue_status_t q_status,
    output logic          push,
    output job_t          push_job
);

    localparam int SW     = (SAMPLE_WIDTH < SAMPLE_W) ? SAMPLE_WIDTH : SAMPLE_W;
    localparam int IDX_W  = $clog2(SAMPLES_PER_DAY);
    localparam int HSUM_W = SW + 2;
    localparam int DSUM_W = SW + IDX_W;
    localparam logic [IDX_W-1:0]  LAST_INDEX = IDX_W'(SAMPLES_PER_DAY - 1);
    localparam logic [HOUR_W-1:0] LAST_HOUR  = HOUR_W'(HOURS_PER_DAY - 1);

    logic [IDX_W-1:0]  index_reg, index_next;
    logic [1:0]        quarter_reg, quarter_next;
    logic [HOUR_W-1:0] hour_reg, hour_next;
    logic [HSUM_W-1:0] hour_sum_reg, hour_sum_next;
    logic [DSUM_W-1:0] day_sum_reg, day_sum_next;
    logic [SW-1:0]     peak_reg, peak_next;
    logic [TIME_W-1:0] peak_time_reg, peak_time_next;
    logic [SW-1:0]     base_reg, base_next;
    logic [TIME_W-1:0] base_time_reg, base_time_next;

    logic [SW-1:0]     sample;
    logic [TIME_W-1:0] now;
    logic [HSUM_W-1:0] hour_sum_new;
    logic [DSUM_W-1:0] day_sum_new;
    logic [SW-1:0]     peak_new, base_new;
    logic [TIME_W-1:0] peak_time_new, base_time_new;
    logic              first, hour_end, day_end, accept;

    assign samples.ready = !q_status.full;
    assign accept        = samples.valid && samples.ready;

    assign sample       = samples.payload.power_sample[SW-1:0];
    assign now          = {hour_reg, quarter_reg};
    assign hour_sum_new = hour_sum_reg + HSUM_W'(sample);
    assign day_sum_new  = day_sum_reg + DSUM_W'(sample);
    assign first        = (index_reg == '0);
    assign hour_end     = (quarter_reg == 2'd3);
    assign day_end      = (index_reg == LAST_INDEX);

    always_comb
    begin
        peak_new      = peak_reg;
        peak_time_new = peak_time_reg;
        base_new      = base_reg;
        base_time_new = base_time_reg;
        if (first || sample > peak_reg)
        begin
            peak_new      = sample;
            peak_time_new = now;
        end
        if (first || sample < base_reg)
        begin
            base_new      = sample;
            base_time_new = now;
        end
    end

    always_comb
    begin
        push_job = '0;
        if (hour_end)
        begin
            push_job.res.hour_index   = hour_reg;
            push_job.res.hour_average = SAMPLE_W'(hour_sum_new[HSUM_W-1:2]);
        end
        if (day_end)
        begin
            push_job.res.day_done    = 1'b1;
            push_job.res.peak_value  = SAMPLE_W'(peak_new);
            push_job.res.peak_hour   = peak_time_new[TIME_W-1:2];
            push_job.res.peak_minute = minute_of(peak_time_new[1:0]);
            push_job.res.base_value  = SAMPLE_W'(base_new);
            push_job.res.base_hour   = base_time_new[TIME_W-1:2];
            push_job.res.base_minute = minute_of(base_time_new[1:0]);
            push_job.day_sum         = DAY_SUM_W'(day_sum_new);
        end
    end

    assign push = accept && (hour_end || day_end);

    always_comb
    begin
        index_next     = index_reg;
        quarter_next   = quarter_reg;
        hour_next      = hour_reg;
        hour_sum_next  = hour_sum_reg;
        day_sum_next   = day_sum_reg;
        peak_next      = peak_reg;
        peak_time_next = peak_time_reg;
        base_next      = base_reg;
        base_time_next = base_time_reg;
        if (accept)
        begin
            if (day_end)
            begin
                index_next     = '0;
                quarter_next   = '0;
                hour_next      = '0;
                hour_sum_next  = '0;
                day_sum_next   = '0;
                peak_next      = '0;
                peak_time_next = '0;
                base_next      = '0;
                base_time_next = '0;
            end
            else
            begin
                index_next     = index_reg + 1'b1;
                day_sum_next   = day_sum_new;
                peak_next      = peak_new;
                peak_time_next = peak_time_new;
                base_next      = base_new;
                base_time_next = base_time_new;
                if (hour_end)
                begin
                    quarter_next  = '0;
                    hour_sum_next = '0;
                    hour_next     = (hour_reg == LAST_HOUR) ? '0 : hour_reg + 1'b1;
                end
                else
                begin
                    quarter_next  = quarter_reg + 1'b1;
                    hour_sum_next = hour_sum_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            quarter_reg   <= '0;
            hour_reg      <= '0;
            hour_sum_reg  <= '0;
            day_sum_reg   <= '0;
            peak_reg      <= '0;
            peak_time_reg <= '0;
            base_reg      <= '0;
            base_time_reg <= '0;
        end
        else
        begin
            index_reg     <= index_next;
            quarter_reg   <= quarter_next;
            hour_reg      <= hour_next;
            hour_sum_reg  <= hour_sum_next;
            day_sum_reg   <= day_sum_next;
            peak_reg      <= peak_next;
            peak_time_reg <= peak_time_next;
            base_reg      <= base_next;
            base_time_reg <= base_time_next;
        end
    end

endmodule

/* rtl/lps_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load profile job queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lps_queue
    import lps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          pop_job,
    output queue_status_t status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign pop_job      = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/lps_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load profile back end
// Computes the day mean by reciprocal multiplication and drives the results.
// ----------------------------------------------------------------------------
module lps_back
    import lps_pkg::*;
#(
    parameter int SAMPLES_PER_DAY = 96
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  job_t          pop_job,
    output logic          pop,
    lps_stream_if.source  results
);

    localparam int PROD_W = 2 * DAY_SUM_W;
    localparam logic [DAY_SUM_W-1:0] RECIP   = DAY_SUM_W'((1 << DAY_SUM_W) / SAMPLES_PER_DAY);
    localparam logic [DAY_SUM_W-1:0] DIVISOR = DAY_SUM_W'(SAMPLES_PER_DAY);

    logic              s1_valid_reg, s1_valid_next;
    job_t              s1_job_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    logic                 s1_en, out_free;
    logic [DAY_SUM_W-1:0] quot_est, remainder, quot;
    logic [PROD_W-1:0]    quot_times_div;
    result_t              formatted;

    assign out_free        = !out_valid_reg || results.ready;
    assign s1_en           = !s1_valid_reg || out_free;
    assign pop             = !q_status.empty && s1_en;
    assign s1_valid_next   = s1_en ? !q_status.empty : s1_valid_reg;
    assign out_valid_next  = out_free ? s1_valid_reg : out_valid_reg;
    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

    // The estimate is at most one below the true quotient.
    assign quot_est       = s1_prod_reg[PROD_W-1:DAY_SUM_W];
    assign quot_times_div = PROD_W'(quot_est) * PROD_W'(DIVISOR);
    assign remainder      = s1_job_reg.day_sum - quot_times_div[DAY_SUM_W-1:0];
    assign quot           = (remainder >= DIVISOR) ? quot_est + 1'b1 : quot_est;

    always_comb
    begin
        formatted          = s1_job_reg.res;
        formatted.day_mean = quot[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_job_reg  <= pop_job;
            s1_prod_reg <= PROD_W'(pop_job.day_sum) * PROD_W'(RECIP);
        end
        if (out_free && s1_valid_reg)
        begin
            out_reg <= formatted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/load_profile_statistics_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load profile statistics
// Hourly averages and daily peak, base and mean of 15-minute power samples.
// ----------------------------------------------------------------------------
// The samples channel takes one power sample item per quarter hour of the
// meter day. The results channel gives one item for every fourth sample,
// carrying the hour's average, and one for the day's last sample, which also
// carries the peak and base load with their first times and the day mean.
// Samples that close neither an hour nor a day give no result item.
// A sample is taken in every cycle while the job queue has room. A result
// item is written into the job queue, then registered in the mean multiplier
// stage and then in the output register. Throughput is one item per cycle
// while the queue has room and the receiver keeps up, set by the front end,
// which updates its state as each sample is taken, and the pipelined back end.
// When the receiver stalls, the result stays in the output register, the
// back end holds, and the four-entry queue absorbs further results; the
// samples channel drops ready only when the queue is full.
// Reset clears the time of day, all sums and extremes and empties the queue.
// ----------------------------------------------------------------------------
module load_profile_statistics_top
    import lps_pkg::*;
#(
    parameter int SAMPLES_PER_DAY = 96,
    parameter int SAMPLE_WIDTH    = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    lps_stream_if.sink   samples,
    lps_stream_if.source results
);

    logic          push;
    job_t          push_job;
    logic          pop;
    job_t          pop_job;
    queue_status_t q_status;

    lps_front #(
        .SAMPLES_PER_DAY (SAMPLES_PER_DAY),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    lps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    lps_back #(
        .SAMPLES_PER_DAY (SAMPLES_PER_DAY)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_job  (pop_job),
        .pop      (pop),
        .results  (results)
    );

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_status.full)
        else $error("Job queue written while full.");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_status.empty)
        else $error("Job queue read while empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.payload.day_done) |->
            (results.payload.peak_value == '0 && results.payload.base_value == '0 &&
             results.payload.day_mean == '0))
        else $error("Day summary fields set on an hourly result item.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.payload.day_done) |->
            (results.payload.peak_value >= results.payload.base_value &&
             results.payload.day_mean <= results.payload.peak_value &&
             results.payload.day_mean >= results.payload.base_value))
        else $error("Day mean outside the range of base and peak load.");

endmodule

/* dv/load_profile_statistics_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load profile statistics testbench
// Feeds whole meter days of 15-minute power samples into the block, with
// random gaps on the sample side and random stalls on the result side. A
// predictor that runs alongside works out every hourly average and every day
// summary. Each result item is then checked field by field, in order.
// ----------------------------------------------------------------------------
module load_profile_statistics_top_tb;
    import lps_pkg::*;

    localparam int SAMPLES_PER_DAY = 96;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int DAYS            = 6;
    localparam int DRAIN_CYCLES    = 12;
    localparam int LIMIT_CYCLES    = 200000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SAMPLE_WIDTH) - 1);

    typedef enum int {
        DAY_UNIFORM,
        DAY_FLAT_MAX,
        DAY_FEW_LEVELS,
        DAY_NEAR_EXTREMES,
        DAY_LATE_EXTREMES
    } day_kind_t;

    logic clk;
    logic rst_n;

    lps_stream_if #(.payload_t(sample_t)) smp_if ();
    lps_stream_if #(.payload_t(result_t)) res_if ();

    load_profile_statistics_top #(
        .SAMPLES_PER_DAY(SAMPLES_PER_DAY),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(smp_if),
        .results(res_if)
    );

    logic [SAMPLE_W-1:0] meter_samples[$];
    result_t             expected_reports[$];

    logic [6:0]           day_count;
    logic [1:0]           quarter_now;
    logic [HOUR_W-1:0]    hour_now;
    logic [17:0]          hour_acc;
    logic [DAY_SUM_W-1:0] day_acc;
    logic [SAMPLE_W-1:0]  peak_load;
    logic [TIME_W-1:0]    peak_at;
    logic [SAMPLE_W-1:0]  base_load;
    logic [TIME_W-1:0]    base_at;

    int samples_taken;
    int hours_checked;
    int days_checked;
    int mismatches;
    int idle_left;
    int stall_left;
    int cycle_count;

    function automatic int pick_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic void clear_day_stats();
        day_count   = '0;
        quarter_now = '0;
        hour_now    = '0;
        hour_acc    = '0;
        day_acc     = '0;
        peak_load   = '0;
        peak_at     = '0;
        base_load   = '0;
        base_at     = '0;
    endfunction

    function automatic void advance_load_profile(input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W-1:0] level;
        logic [TIME_W-1:0]   now;
        logic                closes_hour;
        logic                closes_day;
        result_t             rep;
        level = raw & SAMPLE_MASK;
        now   = {hour_now, quarter_now};
        hour_acc = hour_acc + level;
        day_acc  = day_acc + level;
        if (day_count == 0)
        begin
            peak_load = level;
            peak_at   = now;
            base_load = level;
            base_at   = now;
        end
        else
        begin
            if (level > peak_load)
            begin
                peak_load = level;
                peak_at   = now;
            end
            if (level < base_load)
            begin
                base_load = level;
                base_at   = now;
            end
        end
        closes_hour = (quarter_now == 2'd3);
        closes_day  = (int'(day_count) + 1 >= SAMPLES_PER_DAY);
        rep = '0;
        if (closes_hour)
        begin
            rep.hour_index   = hour_now;
            rep.hour_average = SAMPLE_W'(hour_acc >> 2);
        end
        if (closes_day)
        begin
            rep.day_done    = 1'b1;
            rep.peak_value  = peak_load;
            rep.peak_hour   = peak_at[TIME_W-1:2];
            rep.peak_minute = MINUTE_W'(int'(peak_at[1:0]) * 15);
            rep.base_value  = base_load;
            rep.base_hour   = base_at[TIME_W-1:2];
            rep.base_minute = MINUTE_W'(int'(base_at[1:0]) * 15);
            rep.day_mean    = SAMPLE_W'(day_acc / SAMPLES_PER_DAY);
        end
        if (closes_hour || closes_day)
            expected_reports.push_back(rep);
        if (closes_day)
        begin
            clear_day_stats();
        end
        else
        begin
            day_count = day_count + 1'b1;
            if (closes_hour)
            begin
                quarter_now = '0;
                hour_acc    = '0;
                hour_now    = (int'(hour_now) + 1 >= HOURS_PER_DAY) ? '0 : hour_now + 1'b1;
            end
            else
            begin
                quarter_now = quarter_now + 1'b1;
            end
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val,
                     act_val);
            mismatches++;
        end
    endfunction

    function automatic void check_report(input result_t act);
        result_t exp;
        if (expected_reports.size() == 0)
        begin
            $display("%0t: unexpected result item, expected none actual %h", $time, act);
            mismatches++;
            return;
        end
        exp = expected_reports.pop_front();
        check_field("hour_index", exp.hour_index, act.hour_index);
        check_field("hour_average", exp.hour_average, act.hour_average);
        check_field("day_done", exp.day_done, act.day_done);
        check_field("peak_value", exp.peak_value, act.peak_value);
        check_field("peak_hour", exp.peak_hour, act.peak_hour);
        check_field("peak_minute", exp.peak_minute, act.peak_minute);
        check_field("base_value", exp.base_value, act.base_value);
        check_field("base_hour", exp.base_hour, act.base_hour);
        check_field("base_minute", exp.base_minute, act.base_minute);
        check_field("day_mean", exp.day_mean, act.day_mean);
        if (exp.day_done)
            days_checked++;
        else
            hours_checked++;
    endfunction

    task automatic queue_day(input day_kind_t kind, input int first_slot);
        logic [SAMPLE_W-1:0] levels[3];
        int                  slot;
        for (int k = 0; k < 3; k++)
            levels[k] = SAMPLE_W'($urandom_range(0, 65535));
        for (slot = first_slot; slot < SAMPLES_PER_DAY; slot++)
        begin
            case (kind)
                DAY_FLAT_MAX:
                    meter_samples.push_back(16'hFFFF);
                DAY_FEW_LEVELS:
                    meter_samples.push_back(levels[$urandom_range(0, 2)]);
                DAY_NEAR_EXTREMES:
                    meter_samples.push_back($urandom_range(0, 1) ?
                                            SAMPLE_W'($urandom_range(65532, 65535)) :
                                            SAMPLE_W'($urandom_range(0, 3)));
                DAY_LATE_EXTREMES:
                    if (slot == SAMPLES_PER_DAY - 1)
                        meter_samples.push_back(16'hFFFF);
                    else if (slot == SAMPLES_PER_DAY - 2)
                        meter_samples.push_back(16'h0000);
                    else
                        meter_samples.push_back(SAMPLE_W'($urandom_range(1000, 2000)));
                default:
                    meter_samples.push_back(SAMPLE_W'($urandom_range(0, 65535)));
            endcase
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Sample side: an item is held until accepted, then the next is offered
    // after a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_if.valid   <= 1'b0;
            smp_if.payload <= '0;
            idle_left = 0;
        end
        else
        begin
            if (smp_if.valid && smp_if.ready)
            begin
                advance_load_profile(smp_if.payload.power_sample);
                samples_taken++;
            end
            if (!smp_if.valid || smp_if.ready)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    smp_if.valid <= 1'b0;
                end
                else if (meter_samples.size() > 0)
                begin
                    smp_if.valid                <= 1'b1;
                    smp_if.payload.power_sample <= meter_samples.pop_front();
                    idle_left = pick_gap(((samples_taken / 64) % 4) == 3);
                end
                else
                begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
                check_report(res_if.payload);
            if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
                stall_left = pick_gap((((hours_checked + days_checked) / 16) % 4) == 3);
            end
        end
    end

    initial
    begin
        logic [SAMPLE_W-1:0] opening[$];
        rst_n          = 1'b0;
        smp_if.valid   = 1'b0;
        smp_if.payload = '0;
        res_if.ready   = 1'b0;
        samples_taken  = 0;
        hours_checked  = 0;
        days_checked   = 0;
        mismatches     = 0;
        cycle_count    = 0;
        clear_day_stats();

        // The first sample seeds both extremes; equal later samples must not
        // move the recorded time of the peak or the base.
        opening = '{16'd30000, 16'd30000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                    16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'h0001, 16'h0002, 16'h0003, 16'h0002};
        foreach (opening[i])
            meter_samples.push_back(opening[i]);
        queue_day(DAY_UNIFORM, opening.size());
        for (int d = 1; d < DAYS; d++)
            queue_day(day_kind_t'(d % 5), 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (meter_samples.size() > 0 || smp_if.valid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d samples over %0d days: uniform, flat maximum, few levels,",
                 samples_taken, DAYS);
        $display("near extremes and late extremes; checked %0d hourly and %0d day items.",
                 hours_checked, days_checked);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/lps_pkg.sv
rtl/lps_stream_if.sv
rtl/lps_front.sv
rtl/lps_queue.sv
rtl/lps_back.sv
rtl/load_profile_statistics_top.sv
dv/load_profile_statistics_top_tb.sv
